@@ rtl/slmf_pkg.sv @@
// Shared constants and controller/datapath interface types for the leader filter.
package slmf_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned VALUE_W     = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;      // an input request is accepted this cycle
    logic scan_init;  // set up the backward scan over the buffered run
    logic scan_rd;    // read one buffered value for the scan
    logic emit_rd;    // pop one leader from the stack
    logic emit_ld;    // move the popped leader into the output register
    logic run_done;   // the run is finished, clear the overflow flag
  } slmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the scan address has reached the first entry
    logic stack_empty;
    logic out_taken;  // the output register is handed over this cycle
  } slmf_sts_t;

endpackage

@@ rtl/slmf_ctrl.sv @@
// Sequencing state machine for loading, scanning and emitting one run.
module slmf_ctrl
  import slmf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      end_of_run_i,
  input  slmf_sts_t sts_i,
  output logic      in_stall_o,
  output slmf_cmd_t cmd_o
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_LD    = 3'd5;
  localparam logic [2:0] S_HOLD  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_LOAD);
  assign accept     = in_valid_i && (state_q == S_LOAD);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.store = accept;
        if (accept && end_of_run_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last value read is compared and pushed at this edge.
        state_d = S_POP;
      end
      S_POP: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_LD;
      end
      S_LD: begin
        cmd_o.emit_ld = 1'b1;
        state_d       = S_HOLD;
      end
      S_HOLD: begin
        if (sts_i.out_taken) begin
          if (sts_i.stack_empty) begin
            cmd_o.run_done = 1'b1;
            state_d        = S_LOAD;
          end else begin
            state_d = S_POP;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/slmf_dpath.sv @@
// Value buffer, backward suffix-maximum scan and leader stack with output register.
module slmf_dpath
  import slmf_pkg::*;
#(
  parameter int unsigned MaxLen = MAX_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  slmf_cmd_t                  cmd_i,
  output slmf_sts_t                  sts_o,
  input  logic signed [VALUE_W-1:0]  sample_value_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic signed [VALUE_W-1:0]  kept_value_o,
  output logic                       final_result_o,
  output logic                       overflowed_o
);

  localparam int unsigned CntW  = $clog2(MaxLen + 1);
  localparam int unsigned AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam logic [CntW-1:0] FullCnt = CntW'(MaxLen);

  logic signed [VALUE_W-1:0] buf_mem [MaxLen];
  logic signed [VALUE_W-1:0] stk_mem [MaxLen];

  logic [CntW-1:0]  fill_q;
  logic             ovf_q;
  logic [AddrW-1:0] scan_idx_q;
  logic             first_q;
  logic             rd_vld_q;
  logic             rd_first_q;
  logic signed [VALUE_W-1:0] rd_data_q;
  logic signed [VALUE_W-1:0] best_q;
  logic [CntW-1:0]  sp_q;
  logic [CntW-1:0]  sp_dec;
  logic signed [VALUE_W-1:0] st_data_q;
  logic             push;
  logic             full;
  logic             out_vld_q;

  assign full   = (fill_q == FullCnt);
  assign push   = rd_vld_q && (rd_first_q || !(rd_data_q < best_q));
  assign sp_dec = sp_q - CntW'(1);

  assign sts_o.scan_last   = (scan_idx_q == '0);
  assign sts_o.stack_empty = (sp_q == '0);
  assign sts_o.out_taken   = out_vld_q && !out_stall_i;

  // Buffer memory: write on load, registered read during the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      buf_mem[fill_q[AddrW-1:0]] <= sample_value_i;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= buf_mem[scan_idx_q];
    end
  end

  // Leader stack: leaders are found last-to-first, so popping restores arrival order.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_mem[sp_q[AddrW-1:0]] <= rd_data_q;
    end
    if (cmd_i.emit_rd) begin
      st_data_q <= stk_mem[sp_dec[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      best_q <= rd_data_q;
    end
    if (cmd_i.emit_ld) begin
      kept_value_o   <= st_data_q;
      final_result_o <= (sp_q == '0);
      overflowed_o   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      ovf_q      <= 1'b0;
      scan_idx_q <= '0;
      first_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      sp_q       <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.scan_rd;
      rd_first_q <= cmd_i.scan_rd && first_q;
      if (cmd_i.store) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          fill_q <= fill_q + CntW'(1);
        end
      end
      if (cmd_i.scan_init) begin
        scan_idx_q <= AddrW'(fill_q - CntW'(1));
        fill_q     <= '0;
        sp_q       <= '0;
        first_q    <= 1'b1;
      end
      if (cmd_i.scan_rd) begin
        scan_idx_q <= scan_idx_q - AddrW'(1);
        first_q    <= 1'b0;
      end
      if (push) begin
        sp_q <= sp_q + CntW'(1);
      end
      if (cmd_i.emit_rd) begin
        sp_q <= sp_dec;
      end
      if (cmd_i.run_done) begin
        ovf_q <= 1'b0;
      end
      if (cmd_i.emit_ld) begin
        out_vld_q <= 1'b1;
      end else if (sts_o.out_taken) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ rtl/suffix_max_leader_filter.sv @@
// Top level of the leader filter: emits the suffix-maximum leaders of each run.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+----------------------------------------
//   input   | in        | in_valid_i / in_stall_o   | sample_value_i, end_of_run_i
//   output  | out       | out_valid_o / out_stall_i | kept_value_o, final_result_o, overflowed_o
//
// Each accepted value of a run is written to the buffer memory unless it is full.
// After the request that ends a run, the backward scan reads the buffered values
// last to first, one buffer read per cycle; then each leader is popped from the leader
// stack by a registered read and held in the output register until it is taken.
// The input is stalled from the end of a run until its last leader is taken.
// Reset clears only control state; the memories need no clearing.
module suffix_max_leader_filter
  import slmf_pkg::*;
#(
  parameter int unsigned MaxLen = MAX_LEN_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [VALUE_W-1:0] sample_value_i,
  input  logic                      end_of_run_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] kept_value_o,
  output logic                      final_result_o,
  output logic                      overflowed_o
);

  slmf_cmd_t cmd;
  slmf_sts_t sts;
  logic      in_accept;
  logic      out_accept;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;

  slmf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .end_of_run_i (end_of_run_i),
    .sts_i        (sts),
    .in_stall_o   (in_stall_o),
    .cmd_o        (cmd)
  );

  slmf_dpath #(
    .MaxLen (MaxLen)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_value_i (sample_value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kept_value_o   (kept_value_o),
    .final_result_o (final_result_o),
    .overflowed_o   (overflowed_o)
  );

`ifndef SYNTH
  // Loading and emitting never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_accept && out_valid_o))
    else $error("input accepted while a result is pending");

  // The request that ends a run closes the input until its leaders are out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_of_run_i) |=> in_stall_o)
    else $error("input open right after end of run");

  // Handing over the final leader reopens the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && final_result_o) |=> !in_stall_o)
    else $error("input not reopened after final result");

  // A run ends with exactly one final result: none follows it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && final_result_o) |=> !out_valid_o)
    else $error("result after the final result");
`endif

endmodule
